// ===== sv/dda_lr_pkg.sv =====
// Shared types and constants of the DDA line rasterizer.
`default_nettype none

package dda_lr_pkg;

    // Action codes carried by an input transaction.
    localparam logic ACT_START   = 1'b0;
    localparam logic ACT_ADVANCE = 1'b1;

    // Width of one color component.
    localparam int CLR_BITS = 8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;    // latch the endpoints and color of a start transaction
        logic prep;       // order the endpoints and set up the accumulator
        logic div_start;  // launch the slope division
        logic set_slope;  // take the rounded quotient as the slope
        logic step;       // advance the major axis and the accumulator
        logic load_out;   // load the output register with the current pixel
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic zero_len;   // both endpoints are the same pixel
        logic div_done;   // the quotient is ready
        logic last;       // the pixel being loaded is the final one
    } t_dp_status;

endpackage

`default_nettype wire

// ===== sv/dda_line_rasterizer.sv =====
// Top level of the DDA line rasterizer.
// A start transaction (action 0) latches two endpoints and a color; the block
// orders the endpoints along the major axis, divides for a signed fixed-point
// slope and then delivers the first pixel. After the accept, a setup state
// launches the one-bit-per-cycle restoring divider, the rounded quotient is
// taken as the slope and the output register is loaded with the first pixel
// once it is free; a zero-length line skips the divider and the slope step.
// No input is taken until the first pixel is loaded. Advance transactions
// (action 1) make one add on the major axis and one on the accumulator, so
// pixels stream out at one per clock while the output side keeps up. An
// advance after the final pixel, or before any line, is accepted and produces
// nothing. The final pixel of each line has last_pixel set.
`default_nettype none

module dda_line_rasterizer import dda_lr_pkg::*; #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_action,
    input  wire logic signed [COORD_BITS-1:0]  i_start_x,
    input  wire logic signed [COORD_BITS-1:0]  i_start_y,
    input  wire logic signed [COORD_BITS-1:0]  i_end_x,
    input  wire logic signed [COORD_BITS-1:0]  i_end_y,
    input  wire logic [CLR_BITS-1:0]           i_red_in,
    input  wire logic [CLR_BITS-1:0]           i_green_in,
    input  wire logic [CLR_BITS-1:0]           i_blue_in,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed [COORD_BITS-1:0]       o_pixel_x,
    output logic signed [COORD_BITS-1:0]       o_pixel_y,
    output logic [CLR_BITS-1:0]                o_red_out,
    output logic [CLR_BITS-1:0]                o_green_out,
    output logic [CLR_BITS-1:0]                o_blue_out,
    output logic                               o_last_pixel
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Sequencing and handshakes.
    dda_lr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_action),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Arithmetic and result register.
    dda_lr_datapath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_red_in     (i_red_in),
        .i_green_in   (i_green_in),
        .i_blue_in    (i_blue_in),
        .o_status     (w_status),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_red_out    (o_red_out),
        .o_green_out  (o_green_out),
        .o_blue_out   (o_blue_out),
        .o_last_pixel (o_last_pixel)
    );

endmodule

`default_nettype wire

// ===== sv/dda_lr_div.sv =====
// Restoring divider that forms the unrounded slope quotient one bit per cycle.
`default_nettype none

module dda_lr_div #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [COORD_BITS-1:0]  i_mag,
    input  wire logic [COORD_BITS-1:0]  i_divisor,
    output logic                        o_done,
    output logic [FRAC_BITS+1:0]        o_quotient
);

    // The dividend is the magnitude shifted left by FRAC_BITS + 1.
    localparam int DW = COORD_BITS + FRAC_BITS + 1;
    localparam int QW = FRAC_BITS + 2;
    localparam int CW = $clog2(DW + 1);
    localparam logic [CW-1:0] CNT_INIT = CW'(DW);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);

    logic [COORD_BITS-1:0] r_rem,     n_rem;
    logic [DW-1:0]         r_quo,     n_quo;
    logic [COORD_BITS-1:0] r_divisor, n_divisor;
    logic [CW-1:0]         r_cnt,     n_cnt;
    logic                  r_busy,    n_busy;
    logic                  r_done,    n_done;

    logic [COORD_BITS:0]   w_trial;
    logic [COORD_BITS:0]   w_diff;
    logic                  w_ge;

    // One trial subtraction per cycle.
    always_comb begin
        w_trial = {r_rem, r_quo[DW-1]};
        w_diff  = w_trial - {1'b0, r_divisor};
        w_ge    = (w_trial >= {1'b0, r_divisor});
    end

    // Next-state logic for the iteration.
    always_comb begin
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_divisor = r_divisor;
        n_cnt     = r_cnt;
        n_busy    = r_busy;
        n_done    = 1'b0;
        if (i_start) begin
            n_rem     = '0;
            n_quo     = {i_mag, {(FRAC_BITS + 1){1'b0}}};
            n_divisor = i_divisor;
            n_cnt     = CNT_INIT;
            n_busy    = 1'b1;
        end else if (r_busy) begin
            n_rem  = w_ge ? w_diff[COORD_BITS-1:0] : w_trial[COORD_BITS-1:0];
            n_quo  = {r_quo[DW-2:0], w_ge};
            n_cnt  = r_cnt - CNT_ONE;
            if (r_cnt == CNT_ONE) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Data registers.
    always_ff @(posedge i_clk) begin
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_divisor <= n_divisor;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo[QW-1:0];

endmodule

`default_nettype wire

// ===== sv/dda_lr_datapath.sv =====
// Datapath of the DDA line rasterizer: endpoint setup, slope, accumulator, output register.
`default_nettype none

module dda_lr_datapath import dda_lr_pkg::*; #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_dp_cmd                       i_cmd,
    input  wire logic signed [COORD_BITS-1:0]  i_start_x,
    input  wire logic signed [COORD_BITS-1:0]  i_start_y,
    input  wire logic signed [COORD_BITS-1:0]  i_end_x,
    input  wire logic signed [COORD_BITS-1:0]  i_end_y,
    input  wire logic [CLR_BITS-1:0]           i_red_in,
    input  wire logic [CLR_BITS-1:0]           i_green_in,
    input  wire logic [CLR_BITS-1:0]           i_blue_in,
    output t_dp_status                         o_status,
    output logic signed [COORD_BITS-1:0]       o_pixel_x,
    output logic signed [COORD_BITS-1:0]       o_pixel_y,
    output logic [CLR_BITS-1:0]                o_red_out,
    output logic [CLR_BITS-1:0]                o_green_out,
    output logic [CLR_BITS-1:0]                o_blue_out,
    output logic                               o_last_pixel
);

    localparam int C  = COORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int AW = C + F + 1;   // accumulator, biased by one half
    localparam int SW = F + 2;       // signed slope
    localparam int QW = F + 2;       // unrounded quotient
    localparam logic [C-1:0] POS_ONE = {{(C - 1){1'b0}}, 1'b1};
    localparam logic [QW:0]  Q_ONE   = {{QW{1'b0}}, 1'b1};

    // Latched start transaction.
    logic signed [C-1:0]      r_sx, r_sy, r_ex, r_ey;
    logic [3*CLR_BITS-1:0]    r_color;

    // Line state.
    logic signed [C-1:0]      r_pos, r_end;
    logic signed [AW-1:0]     r_acc;
    logic signed [SW-1:0]     r_slope;
    logic                     r_steep;
    logic                     r_neg;

    // Output register.
    logic signed [C-1:0]      r_px, r_py;
    logic [CLR_BITS-1:0]      r_red, r_green, r_blue;
    logic                     r_last;

    // Setup signals.
    logic signed [C:0]        w_dx, w_dy, w_ndx, w_ndy;
    logic [C-1:0]             w_adx, w_ady;
    logic                     w_steep, w_rev, w_neg;
    logic signed [C-1:0]      w_maj0, w_maj1, w_min0, w_min1;
    logic signed [C-1:0]      w_a0, w_a1, w_b0;
    logic [C-1:0]             w_divisor, w_mag;

    // Slope and stepping signals.
    logic                     w_div_done;
    logic [QW-1:0]            w_quo;
    logic [QW:0]              w_qsum;
    logic signed [SW-1:0]     w_q;
    logic signed [AW-1:0]     w_slope_ext;
    logic signed [C-1:0]      w_pos_nx;
    logic signed [AW-1:0]     w_acc_nx;
    logic signed [C-1:0]      w_minor;
    logic                     w_last;

    // Swap the axes of a steep line and order the endpoints along the major axis.
    always_comb begin
        w_dx    = {r_ex[C-1], r_ex} - {r_sx[C-1], r_sx};
        w_dy    = {r_ey[C-1], r_ey} - {r_sy[C-1], r_sy};
        w_ndx   = -w_dx;
        w_ndy   = -w_dy;
        w_adx   = w_dx[C] ? w_ndx[C-1:0] : w_dx[C-1:0];
        w_ady   = w_dy[C] ? w_ndy[C-1:0] : w_dy[C-1:0];
        w_steep = (w_ady > w_adx);
        w_maj0  = w_steep ? r_sy : r_sx;
        w_maj1  = w_steep ? r_ey : r_ex;
        w_min0  = w_steep ? r_sx : r_sy;
        w_min1  = w_steep ? r_ex : r_ey;
        w_rev   = w_steep ? w_dy[C] : w_dx[C];
        w_neg   = (w_steep ? w_dx[C] : w_dy[C]) ^ w_rev;
        w_a0    = w_rev ? w_maj1 : w_maj0;
        w_a1    = w_rev ? w_maj0 : w_maj1;
        w_b0    = w_rev ? w_min1 : w_min0;
        w_divisor = w_steep ? w_ady : w_adx;
        w_mag     = w_steep ? w_adx : w_ady;
    end

    dda_lr_div #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_mag      (w_mag),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // Round the quotient magnitude half away from zero; the sign is applied when the slope is set.
    always_comb begin
        w_qsum = {1'b0, w_quo} + Q_ONE;
        w_q    = $signed(w_qsum[QW:1]);
    end

    // Next pixel: one add on the major axis, one on the accumulator.
    always_comb begin
        w_slope_ext = {{(AW - SW){r_slope[SW-1]}}, r_slope};
        w_pos_nx    = i_cmd.step ? (r_pos + $signed(POS_ONE)) : r_pos;
        w_acc_nx    = i_cmd.step ? (r_acc + w_slope_ext) : r_acc;
        w_minor     = $signed(w_acc_nx[F +: C]);
        w_last      = (w_pos_nx >= r_end);
    end

    // Line state and latched transaction.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_sx    <= i_start_x;
            r_sy    <= i_start_y;
            r_ex    <= i_end_x;
            r_ey    <= i_end_y;
            r_color <= {i_red_in, i_green_in, i_blue_in};
        end
        if (i_cmd.prep) begin
            r_pos   <= w_a0;
            r_end   <= w_a1;
            r_acc   <= $signed({w_b0[C-1], w_b0, 1'b1, {(F - 1){1'b0}}});
            r_slope <= '0;
            r_steep <= w_steep;
            r_neg   <= w_neg;
        end
        if (i_cmd.set_slope) begin
            r_slope <= r_neg ? -w_q : w_q;
        end
        if (i_cmd.step) begin
            r_pos <= w_pos_nx;
            r_acc <= w_acc_nx;
        end
    end

    // Output register; steep pixels are swapped back to x and y.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_px    <= r_steep ? w_minor : w_pos_nx;
            r_py    <= r_steep ? w_pos_nx : w_minor;
            r_red   <= r_color[3*CLR_BITS-1:2*CLR_BITS];
            r_green <= r_color[2*CLR_BITS-1:CLR_BITS];
            r_blue  <= r_color[CLR_BITS-1:0];
            r_last  <= w_last;
        end
    end

    always_comb begin
        o_status.zero_len = (r_sx == r_ex) && (r_sy == r_ey);
        o_status.div_done = w_div_done;
        o_status.last     = w_last;
    end

    assign o_pixel_x    = r_px;
    assign o_pixel_y    = r_py;
    assign o_red_out    = r_red;
    assign o_green_out  = r_green;
    assign o_blue_out   = r_blue;
    assign o_last_pixel = r_last;

endmodule

`default_nettype wire

// ===== sv/dda_lr_ctrl.sv =====
// Controller of the DDA line rasterizer: sequencing, line status and output valid.
`default_nettype none

module dda_lr_ctrl import dda_lr_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_action,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    input  wire t_dp_status  i_status,
    output t_dp_cmd          o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] r_state,     n_state;
    logic       r_active,    n_active;
    logic       r_out_valid, n_out_valid;

    logic       w_out_free;
    logic       w_take;
    logic       w_accept;

    // Transactions are taken in idle whenever the output register can be refilled.
    always_comb begin
        w_out_free = !r_out_valid || !i_out_stall;
        w_take     = (r_state == ST_IDLE) && w_out_free;
        w_accept   = i_in_valid && w_take;
    end

    // Datapath commands.
    always_comb begin
        o_cmd.load_in   = w_accept && (i_action == ACT_START);
        o_cmd.step      = w_accept && (i_action == ACT_ADVANCE) && r_active;
        o_cmd.prep      = (r_state == ST_PREP);
        o_cmd.div_start = (r_state == ST_PREP) && !i_status.zero_len;
        o_cmd.set_slope = (r_state == ST_DIV) && i_status.div_done;
        o_cmd.load_out  = o_cmd.step || ((r_state == ST_EMIT) && w_out_free);
    end

    // State sequencing.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.load_in) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_state = i_status.zero_len ? ST_EMIT : ST_DIV;
            end
            ST_DIV: begin
                if (i_status.div_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Line status and output valid.
    always_comb begin
        n_active = r_active;
        if (o_cmd.load_out) begin
            n_active = !i_status.last;
        end else if (o_cmd.load_in) begin
            n_active = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = !w_take;
    assign o_out_valid = r_out_valid;

    // A held result is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !o_cmd.load_out)
        else $error("output register loaded while a result is held");

    // The quotient moves the sequencer straight to the first pixel.
    a_div_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && i_status.div_done) |=> (r_state == ST_EMIT))
        else $error("divider completion did not lead to the first pixel");

    // Setup always leads to the division or the first pixel.
    a_prep_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PREP) |=> (r_state == ST_DIV || r_state == ST_EMIT))
        else $error("setup cycle followed by an unexpected state");

    // The final pixel ends the line.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_out && i_status.last) |=> !r_active)
        else $error("line still active after its final pixel");

endmodule

`default_nettype wire

// ===== tb/sv/dda_line_rasterizer_test.sv =====
// Self-checking testbench for the DDA line rasterizer: directed table, then random lines.
`timescale 1ns / 1ps

module dda_line_rasterizer_test import dda_lr_pkg::*;;

    localparam int CW = 12;           // coordinate width
    localparam int FW = 16;           // fraction bits of the slope and accumulator
    localparam int AW = CW + FW + 1;  // minor accumulator width
    localparam int SW = FW + 2;       // slope width
    localparam int CMIN = -(1 << (CW - 1));
    localparam int CMAX = (1 << (CW - 1)) - 1;
    localparam int HALF = 1 << (FW - 1);
    localparam int ITEM_TARGET = 1350;
    localparam int TAIL_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    typedef struct packed {
        logic                  action;
        logic signed [CW-1:0]  sx;
        logic signed [CW-1:0]  sy;
        logic signed [CW-1:0]  ex;
        logic signed [CW-1:0]  ey;
        logic [CLR_BITS-1:0]   r;
        logic [CLR_BITS-1:0]   g;
        logic [CLR_BITS-1:0]   b;
    } t_item;

    typedef struct packed {
        logic signed [CW-1:0]  x;
        logic signed [CW-1:0]  y;
        logic [CLR_BITS-1:0]   r;
        logic [CLR_BITS-1:0]   g;
        logic [CLR_BITS-1:0]   b;
        logic                  last;
    } t_pixel;

    // One row of the directed table; typed rows carry their own expected pixel.
    typedef struct {
        t_item  it;
        bit     typed;
        bit     has_pix;
        t_pixel pix;
    } t_dir_row;

    localparam t_item  ADV_ITEM = '{action: ACT_ADVANCE, default: '0};
    localparam t_pixel NO_PIX   = '0;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_stall = 1'b0;
    t_item drv_item = '0;
    bit drv_typed = 1'b0;
    bit drv_has_pix = 1'b0;
    t_pixel drv_pix = '0;

    logic o_in_stall;
    logic o_out_valid;
    logic signed [CW-1:0] o_pixel_x;
    logic signed [CW-1:0] o_pixel_y;
    logic [CLR_BITS-1:0] o_red_out;
    logic [CLR_BITS-1:0] o_green_out;
    logic [CLR_BITS-1:0] o_blue_out;
    logic o_last_pixel;

    // Rasterizer state as predicted by the testbench.
    logic signed [CW-1:0] ln_major = '0;
    logic signed [CW-1:0] ln_end = '0;
    logic signed [AW-1:0] ln_accum = '0;
    logic signed [SW-1:0] ln_slope = '0;
    logic ln_steep = 1'b0;
    logic ln_active = 1'b0;
    logic [3*CLR_BITS-1:0] ln_colour = '0;

    t_pixel pixel_q[$];
    t_dir_row dir_rows[25];
    int errors = 0;
    int items_done = 0;
    int unsigned cycles = 0;
    int stall_left = 0;
    bit quiet = 1'b0;
    t_pixel mon_act;
    t_pixel mon_exp;
    t_pixel mon_pix;
    bit mon_got;

    dda_line_rasterizer #(
        .COORD_BITS(CW),
        .FRAC_BITS(FW)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(o_in_stall),
        .i_action(drv_item.action),
        .i_start_x(drv_item.sx),
        .i_start_y(drv_item.sy),
        .i_end_x(drv_item.ex),
        .i_end_y(drv_item.ey),
        .i_red_in(drv_item.r),
        .i_green_in(drv_item.g),
        .i_blue_in(drv_item.b),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_pixel_x(o_pixel_x),
        .o_pixel_y(o_pixel_y),
        .o_red_out(o_red_out),
        .o_green_out(o_green_out),
        .o_blue_out(o_blue_out),
        .o_last_pixel(o_last_pixel)
    );

    always #5 i_clk = ~i_clk;

    // Advance the line state by one transaction; returns 1 when a pixel comes out.
    function automatic bit rasterize_item(input t_item it, output t_pixel px);
        int a0, b0, a1, b1, da, db, t, mag, quot, rnd;
        logic signed [CW-1:0] minor;
        bit last;
        if (it.action == ACT_START) begin
            a0 = int'(it.sx);
            b0 = int'(it.sy);
            a1 = int'(it.ex);
            b1 = int'(it.ey);
            da = a1 - a0;
            db = b1 - b0;
            // Equal spans stay shallow.
            ln_steep = (db < 0 ? -db : db) > (da < 0 ? -da : da);
            if (ln_steep) begin
                t = a0; a0 = b0; b0 = t;
                t = a1; a1 = b1; b1 = t;
            end
            // Reversed endpoints are walked from the lower major coordinate.
            if (a1 < a0) begin
                t = a0; a0 = a1; a1 = t;
                t = b0; b0 = b1; b1 = t;
            end
            da = a1 - a0;
            db = b1 - b0;
            if (da == 0) begin
                ln_slope = '0;
            end else begin
                mag = db < 0 ? -db : db;
                quot = (((mag << (FW + 1)) / da) + 1) >> 1;
                ln_slope = SW'(db < 0 ? -quot : quot);
            end
            ln_major = CW'(a0);
            ln_end = CW'(a1);
            ln_accum = AW'(b0 * (1 << FW));
            ln_colour = {it.r, it.g, it.b};
        end else begin
            if (!ln_active) return 1'b0;
            ln_major = ln_major + CW'(1);
            ln_accum = ln_accum + ln_slope;
        end
        last = ln_major >= ln_end;
        ln_active = !last;
        // Minor coordinate is floor(accumulator + one half).
        rnd = (int'(ln_accum) + HALF) >>> FW;
        minor = CW'(rnd);
        px.x = ln_steep ? minor : ln_major;
        px.y = ln_steep ? ln_major : minor;
        {px.r, px.g, px.b} = ln_colour;
        px.last = last;
        return 1'b1;
    endfunction

    function automatic t_item mk_start(int sx, int sy, int ex, int ey,
                                       logic [3*CLR_BITS-1:0] rgb);
        t_item it;
        it.action = ACT_START;
        it.sx = CW'(sx);
        it.sy = CW'(sy);
        it.ex = CW'(ex);
        it.ey = CW'(ey);
        {it.r, it.g, it.b} = rgb;
        return it;
    endfunction

    function automatic t_pixel mk_pix(int x, int y, logic [3*CLR_BITS-1:0] rgb, logic last);
        t_pixel p;
        p.x = CW'(x);
        p.y = CW'(y);
        {p.r, p.g, p.b} = rgb;
        p.last = last;
        return p;
    endfunction

    function automatic t_item rand_item(logic act);
        t_item it;
        it.action = act;
        it.sx = CW'($urandom);
        it.sy = CW'($urandom);
        it.ex = CW'($urandom);
        it.ey = CW'($urandom);
        it.r = CLR_BITS'($urandom);
        it.g = CLR_BITS'($urandom);
        it.b = CLR_BITS'($urandom);
        return it;
    endfunction

    function automatic int clamp_coord(int v);
        return v > CMAX ? CMAX : (v < CMIN ? CMIN : v);
    endfunction

    // Mostly back-to-back, sometimes a short gap, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Drive one input transaction, hold it until accepted, then idle a while.
    task automatic send_item(input t_item it, input bit typed, input bit has_pix,
                             input t_pixel pix);
        int gap;
        @(negedge i_clk);
        drv_item <= it;
        drv_typed <= typed;
        drv_has_pix <= has_pix;
        drv_pix <= pix;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
        end
    endtask

    // Hold off the sender until every expected pixel has been delivered.
    task automatic drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pixel_q.size() != 0) @(negedge i_clk);
    endtask

    // One random line: a start and its advances, sometimes cut short or overrun.
    task automatic random_line();
        t_item it;
        int kind, dx, dy, span, n_adv, extra;
        it = rand_item(ACT_START);
        kind = $urandom_range(0, 99);
        if (kind >= 4) begin
            dx = int'($urandom_range(0, 40)) - 20;
            dy = int'($urandom_range(0, 40)) - 20;
            if (kind < 7) dy = 0;
            else if (kind < 10) dx = 0;
            else if (kind < 14) dy = $urandom_range(0, 1) ? dx : -dx;
            else if (kind < 19) begin
                dx = 0;
                dy = 0;
            end
            it.ex = CW'(clamp_coord(int'(it.sx) + dx));
            it.ey = CW'(clamp_coord(int'(it.sy) + dy));
        end
        dx = int'(it.ex) - int'(it.sx);
        dy = int'(it.ey) - int'(it.sy);
        dx = dx < 0 ? -dx : dx;
        dy = dy < 0 ? -dy : dy;
        span = dx > dy ? dx : dy;
        n_adv = span;
        // Long lines are abandoned early by the next start.
        if (kind < 4 && span > 40) n_adv = $urandom_range(0, 40);
        else if ($urandom_range(0, 9) == 0) n_adv = $urandom_range(0, span);
        extra = (n_adv == span && $urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
        send_item(it, 1'b0, 1'b0, NO_PIX);
        repeat (n_adv + extra) send_item(rand_item(ACT_ADVANCE), 1'b0, 1'b0, NO_PIX);
        items_done += 1 + n_adv;
        if ($urandom_range(0, 19) == 0) drain();
        if ($urandom_range(0, 9) == 0) quiet <= ~quiet;
    endtask

    // Output-side stall: mostly ready, with short and occasional long bursts.
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 99) < 25) begin
            out_stall <= 1'b1;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                      : $urandom_range(0, 2);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Check delivered pixels first, then predict for the accepted input transaction.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !out_stall) begin
                mon_act = '{o_pixel_x, o_pixel_y, o_red_out, o_green_out, o_blue_out,
                            o_last_pixel};
                if (pixel_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected pixel x=%0d y=%0d rgb=%h%h%h last=%0b",
                                 mon_act.x, mon_act.y, mon_act.r, mon_act.g, mon_act.b,
                                 mon_act.last);
                end else begin
                    mon_exp = pixel_q.pop_front();
                    if (mon_exp.x !== mon_act.x || mon_exp.y !== mon_act.y ||
                        mon_exp.r !== mon_act.r || mon_exp.g !== mon_act.g ||
                        mon_exp.b !== mon_act.b || mon_exp.last !== mon_act.last) begin
                        errors++;
                        if (errors <= 10) begin
                            $write("pixel mismatch: expected x=%0d y=%0d rgb=%h%h%h last=%0b,",
                                   mon_exp.x, mon_exp.y, mon_exp.r, mon_exp.g, mon_exp.b,
                                   mon_exp.last);
                            $display(" got x=%0d y=%0d rgb=%h%h%h last=%0b",
                                     mon_act.x, mon_act.y, mon_act.r, mon_act.g,
                                     mon_act.b, mon_act.last);
                        end
                    end
                end
            end
            if (in_valid && !o_in_stall) begin
                mon_got = rasterize_item(drv_item, mon_pix);
                if (drv_typed) begin
                    if (drv_has_pix) pixel_q.push_back(drv_pix);
                end else if (mon_got) begin
                    pixel_q.push_back(mon_pix);
                end
            end
        end
    end

    // Guard against a hung handshake.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        dir_rows = '{
            // Advance with no line in progress is ignored.
            '{ADV_ITEM, 1'b1, 1'b0, NO_PIX},
            // Zero-length lines give one final pixel.
            '{mk_start(0, 0, 0, 0, 24'hff0080), 1'b1, 1'b1,
              mk_pix(0, 0, 24'hff0080, 1'b1)},
            '{ADV_ITEM, 1'b1, 1'b0, NO_PIX},
            '{mk_start(CMIN, CMAX, CMIN, CMAX, 24'h00ff7f), 1'b1, 1'b1,
              mk_pix(CMIN, CMAX, 24'h00ff7f, 1'b1)},
            // Reversed horizontal line at the right edge, run past its end.
            '{mk_start(CMAX, CMIN, CMAX - 3, CMIN, 24'h0180fe), 1'b1, 1'b1,
              mk_pix(CMAX - 3, CMIN, 24'h0180fe, 1'b0)},
            '{ADV_ITEM, 1'b0, 1'b0, NO_PIX},
            '{ADV_ITEM, 1'b0, 1'b0, NO_PIX},
            '{ADV_ITEM, 1'b0, 1'b0, NO_PIX},
            '{ADV_ITEM, 1'b0, 1'b0, NO_PIX},
            // Full-range diagonal with equal spans, abandoned by the next start.
            '{mk_start(CMIN, CMIN, CMAX, CMAX, 24'hffffff), 1'b1, 1'b1,
              mk_pix(CMIN, CMIN, 24'hffffff, 1'b0)},
            '{ADV_ITEM, 1'b0, 1'b0, NO_PIX},
            '{ADV_ITEM, 1'b0, 1'b0, NO_PIX},
            // Steep line, swapped back on output.
            '{mk_start(0, 0, 1, 5, 24'h123456), 1'b0, 1'b0, NO_PIX},
            '{ADV_ITEM, 1'b0, 1'b0, NO_PIX},
            '{ADV_ITEM, 1'b0, 1'b0, NO_PIX},
            '{ADV_ITEM, 1'b0, 1'b0, NO_PIX},
            '{ADV_ITEM, 1'b0, 1'b0, NO_PIX},
            '{ADV_ITEM, 1'b0, 1'b0, NO_PIX},
            // Steep and reversed.
            '{mk_start(3, 10, 0, 0, 24'haa550f), 1'b0, 1'b0, NO_PIX},
            '{ADV_ITEM, 1'b0, 1'b0, NO_PIX},
            '{ADV_ITEM, 1'b0, 1'b0, NO_PIX},
            // Equal spans with a falling minor axis.
            '{mk_start(0, 0, 3, -3, 24'h808080), 1'b0, 1'b0, NO_PIX},
            '{ADV_ITEM, 1'b0, 1'b0, NO_PIX},
            '{ADV_ITEM, 1'b0, 1'b0, NO_PIX},
            // Half slope lands on a rounding tie.
            '{mk_start(0, 0, 2, 1, 24'h5a5aa5), 1'b0, 1'b0, NO_PIX}
        };

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].has_pix,
                      dir_rows[i].pix);
        drain();

        while (items_done < ITEM_TARGET) random_line();

        // Let the last pixels arrive, then allow for a trailing start.
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/dda_lr_pkg.sv
sv/dda_lr_div.sv
sv/dda_lr_datapath.sv
sv/dda_lr_ctrl.sv
sv/dda_line_rasterizer.sv
tb/sv/dda_line_rasterizer_test.sv
